>>> src/l1u8_pkg.sv
// Shared types and constants of the Latin-1 / UTF-8 byte transcoder.
// Used by the front end, the op queue, the back end and the top level.
`default_nettype none

package l1u8_pkg;

  // Payload of one input word and of one result word.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_string;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
  } out_item_t;

  // Configuration register map.
  localparam int unsigned NUM_REGS  = 2;
  localparam int unsigned PADDR_W   = 3;
  localparam int unsigned PDATA_W   = 32;
  localparam logic [PADDR_W-1:0] ADDR_DIRECTION = 3'd0;
  localparam logic [PADDR_W-1:0] ADDR_CODEPAGE  = 3'd4;

  typedef enum logic {
    DIR_ENCODE = 1'b0,
    DIR_DECODE = 1'b1
  } dir_e;

  localparam logic [1:0] CP_PASSTHROUGH = 2'd0;
  localparam logic [1:0] CP_LATIN1      = 2'd1;
  localparam logic [1:0] CP_RESET       = CP_LATIN1;

  typedef struct packed {
    dir_e       direction;
    logic [1:0] codepage_class;
  } cfg_t;

  // Byte constants of the conversion.
  localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
  localparam logic [7:0] UTF8_CONT  = 8'h80;
  localparam logic [7:0] QMARK      = 8'h3F;

  // What the back end must emit for one input word.
  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_ONE  = 2'd1,
    OP_TWO  = 2'd2
  } op_kind_e;

  typedef struct packed {
    op_kind_e   kind;
    logic [7:0] byte_a;
    logic [7:0] byte_b;
  } op_t;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

endpackage

`default_nettype wire

>>> src/latin1_utf8_byte_transcoder_core.sv
// Latin-1 / UTF-8 byte transcoder, top level with the configuration registers.
// Instantiates l1u8_front, l1u8_queue and l1u8_back; depends on l1u8_pkg.
`default_nettype none

// Takes one byte per cycle while the op queue is not full, and gives one result
// word per cycle while pop is asserted. A byte that encodes to a two-byte UTF-8
// sequence holds the output register for both of its result words, and the back
// end reads no new op while the second one is pending; a two-entry op queue
// absorbs short bursts of them. Held lead bytes and swallowed continuation bytes
// produce no result and never enter the op queue. The first result word of a
// byte is registered in the op queue and then in the output register. Configuration
// is written through the APB port: direction at address 0, codepage class at 4.
module latin1_utf8_byte_transcoder_core import l1u8_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  input  wire logic               push,
  output logic                    full,
  input  wire in_item_t           in_item_i,
  input  wire logic               pop,
  output logic                    empty,
  output out_item_t               out_item_o
);

  cfg_t       cfg_q;
  logic       cfg_wr;
  logic       q_wr;
  op_t        q_wr_op;
  logic       q_full;
  logic       q_rd;
  logic       q_empty;
  op_t        q_rd_op;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // Registers decode on the word address only.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.direction      <= DIR_ENCODE;
      cfg_q.codepage_class <= CP_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == ADDR_CODEPAGE[2]) begin
        cfg_q.codepage_class <= pwdata[1:0];
      end else begin
        cfg_q.direction <= dir_e'(pwdata[0]);
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == ADDR_CODEPAGE[2]) begin
      prdata[1:0] = cfg_q.codepage_class;
    end else begin
      prdata[0] = cfg_q.direction;
    end
  end

  assign full = q_full;

  l1u8_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .push_i   (push),
    .item_i   (in_item_i),
    .q_full_i (q_full),
    .q_wr_o   (q_wr),
    .q_op_o   (q_wr_op)
  );

  l1u8_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (q_wr),
    .wr_op_i (q_wr_op),
    .full_o  (q_full),
    .rd_i    (q_rd),
    .empty_o (q_empty),
    .rd_op_o (q_rd_op)
  );

  l1u8_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_op_i    (q_rd_op),
    .q_rd_o    (q_rd),
    .pop_i     (pop),
    .empty_o   (empty),
    .item_o    (out_item_o)
  );

endmodule

`default_nettype wire

>>> src/l1u8_front.sv
// Front end: accepts input words, tracks the decode state and turns each word
// into an op for the back end. Depends on l1u8_pkg.
`default_nettype none

module l1u8_front import l1u8_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire cfg_t     cfg_i,
  input  wire logic     push_i,
  input  wire in_item_t item_i,
  input  wire logic     q_full_i,
  output logic          q_wr_o,
  output op_t           q_op_o
);

  logic [1:0] held_q, held_d;
  logic       lead_q, lead_d;
  logic       skip_q, skip_d;
  logic       accept;
  logic [7:0] b;
  logic       high;
  op_t        op;

  assign accept = push_i && !q_full_i;
  assign b      = item_i.in_byte;
  assign high   = b[7] && (cfg_i.codepage_class != CP_PASSTHROUGH);

  always_comb begin
    op.kind   = OP_NONE;
    op.byte_a = b;
    op.byte_b = UTF8_CONT | {2'b00, b[5:0]};
    held_d    = held_q;
    lead_d    = lead_q;
    skip_d    = skip_q;
    if (cfg_i.direction == DIR_ENCODE) begin
      held_d = 2'b00;
      lead_d = 1'b0;
      skip_d = 1'b0;
      if (high) begin
        op.kind   = OP_TWO;
        op.byte_a = UTF8_LEAD2 | {6'b000000, b[7:6]};
      end else begin
        op.kind = OP_ONE;
      end
    end else if (lead_q) begin
      op.kind   = OP_ONE;
      op.byte_a = {held_q, b[5:0]};
      lead_d    = 1'b0;
      held_d    = 2'b00;
    end else if (skip_q && (b[7:6] == 2'b10)) begin
      op.kind = OP_NONE;
    end else begin
      skip_d = 1'b0;
      if (!high) begin
        op.kind = OP_ONE;
      end else if ((b[7:5] == 3'b110) && !item_i.end_of_string &&
                   (cfg_i.codepage_class == CP_LATIN1)) begin
        // A two-byte lead is held until the next word completes it.
        held_d = b[1:0];
        lead_d = 1'b1;
      end else begin
        op.kind   = OP_ONE;
        op.byte_a = QMARK;
        skip_d    = 1'b1;
      end
    end
    if (item_i.end_of_string) begin
      held_d = 2'b00;
      lead_d = 1'b0;
      skip_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= 2'b00;
      lead_q <= 1'b0;
      skip_q <= 1'b0;
    end else if (accept) begin
      held_q <= held_d;
      lead_q <= lead_d;
      skip_q <= skip_d;
    end
  end

  // Words that produce nothing never enter the queue.
  assign q_wr_o = accept && (op.kind != OP_NONE);
  assign q_op_o = op;

endmodule

`default_nettype wire

>>> src/l1u8_queue.sv
// Short op queue that decouples the front end from the back end.
// Register-based ring with a fall-through head. Depends on l1u8_pkg.
`default_nettype none

module l1u8_queue import l1u8_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic wr_i,
  input  wire op_t  wr_op_i,
  output logic      full_o,
  input  wire logic rd_i,
  output logic      empty_o,
  output op_t       rd_op_o
);

  op_t              slot_q [QDEPTH];
  logic [QPTR_W-1:0] wptr_q, wptr_d;
  logic [QPTR_W-1:0] rptr_q, rptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign rd_op_o = slot_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (wr_i) begin
      wptr_d = (wptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wptr_q + QPTR_W'(1);
    end
    if (rd_i) begin
      rptr_d = (rptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rptr_q + QPTR_W'(1);
    end
    case ({wr_i, rd_i})
      2'b10:   cnt_d = cnt_q + QCNT_W'(1);
      2'b01:   cnt_d = cnt_q - QCNT_W'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      slot_q[wptr_q] <= wr_op_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_i |-> !full_o)
    else $error("op queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_i |-> !empty_o)
    else $error("op queue read while empty");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCNT_W'(QDEPTH))
    else $error("op queue count out of range");

  a_no_empty_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_i |-> (wr_op_i.kind != OP_NONE))
    else $error("op that emits nothing entered the queue");

endmodule

`default_nettype wire

>>> src/l1u8_back.sv
// Back end: expands queued ops into one or two result words and holds the
// oldest result in an output register. Depends on l1u8_pkg.
`default_nettype none

module l1u8_back import l1u8_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic q_empty_i,
  input  wire op_t  q_op_i,
  output logic      q_rd_o,
  input  wire logic pop_i,
  output logic      empty_o,
  output out_item_t item_o
);

  logic       out_valid_q;
  out_item_t  out_q;
  logic       pend_q;
  logic [7:0] pend_byte_q;
  logic       out_free;

  // The register can take a new word when it is empty or being drained.
  assign out_free = !out_valid_q || pop_i;
  assign q_rd_o   = out_free && !pend_q && !q_empty_i;
  assign empty_o  = !out_valid_q;
  assign item_o   = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else if (out_free) begin
      if (pend_q) begin
        out_valid_q <= 1'b1;
        pend_q      <= 1'b0;
      end else if (!q_empty_i) begin
        out_valid_q <= 1'b1;
        pend_q      <= (q_op_i.kind == OP_TWO);
      end else begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (pend_q) begin
        out_q.out_byte <= pend_byte_q;
        out_q.run_last <= 1'b1;
      end else if (!q_empty_i) begin
        out_q.out_byte <= q_op_i.byte_a;
        out_q.run_last <= (q_op_i.kind != OP_TWO);
        pend_byte_q    <= q_op_i.byte_b;
      end
    end
  end

  a_pend_has_lead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (out_valid_q && !out_q.run_last))
    else $error("second byte pending without its lead on the output");

endmodule

`default_nettype wire
